[rtl/core/qmfr_pkg.sv]
package qmfr_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] port_pins;
		logic       third_button_pin;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [2:0] buttons;
		logic [7:0] dx;
		logic [7:0] dy;
	} report_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam int BTN0_BIT  = 7;
	localparam int BTN1_BIT  = 6;
	localparam int X_HI_BIT  = 5;
	localparam int X_LO_BIT  = 3;
	localparam int Y_HI_BIT  = 4;
	localparam int Y_LO_BIT  = 2;

	localparam logic [7:0] TERMINATOR = 8'd10;

	localparam int NUM_BUTTONS = 3;
	localparam int DELTA_BITS  = 8;
	localparam int REPORT_LEN  = NUM_BUTTONS + 2 * DELTA_BITS + 1;
	localparam int IDX_W       = $clog2(REPORT_LEN);

	localparam int QUEUE_DEPTH = 2;

	// Gray order 00 -> 01 -> 11 -> 10 counts up
	function automatic logic [1:0] step_up(input logic [1:0] ph);
		logic [1:0] r;
		unique case (ph)
			2'b00:   r = 2'b01;
			2'b01:   r = 2'b11;
			2'b11:   r = 2'b10;
			default: r = 2'b00;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] step_down(input logic [1:0] ph);
		logic [1:0] r;
		unique case (ph)
			2'b00:   r = 2'b10;
			2'b10:   r = 2'b11;
			2'b11:   r = 2'b01;
			default: r = 2'b00;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/quadrature_mouse_frame_reporter.sv]
// Two-axis quadrature mouse decoder. Sample items (cmd 0) update the X and Y
// position counters and latch the three button levels; they are accepted
// every clock. A tick item (cmd 1) snapshots the per-axis deltas and buttons
// into a report queue of QUEUE_DEPTH entries and is accepted whenever that
// queue has room; the report drains as 20 bytes (3 button flags, 8 X bits
// LSB first, 8 Y bits, newline with last set), one byte per cycle while
// report_ready is high, through a registered output; a tick stalls the
// input only while the report queue is full.
module quadrature_mouse_frame_reporter #(
	parameter int QUEUE_DEPTH = qmfr_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  qmfr_pkg::in_item_t  item,
	output logic               report_valid,
	input  logic               report_ready,
	output qmfr_pkg::out_item_t report
);

	logic              q_full, q_push, q_pop, q_valid;
	qmfr_pkg::report_t q_wdata, q_rdata;

	qmfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	qmfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rdata    (q_rdata)
	);

	qmfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

endmodule

[rtl/core/qmfr_front.sv]
module qmfr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  qmfr_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_push,
	output qmfr_pkg::report_t  q_wdata
);

	logic [7:0] count_x_q, count_y_q;
	logic [7:0] prev_x_q, prev_y_q;
	logic [1:0] phase_x_q, phase_y_q;
	logic [2:0] buttons_q;

	logic [7:0] data;
	logic [1:0] xp, yp;
	logic       accept, is_tick;

	assign is_tick    = (item.cmd == qmfr_pkg::CMD_TICK);
	assign item_ready = !is_tick || !q_full;
	assign accept     = item_valid && item_ready;
	assign q_push     = accept && is_tick;

	assign data = ~item.port_pins;
	assign xp   = {data[qmfr_pkg::X_HI_BIT], data[qmfr_pkg::X_LO_BIT]};
	assign yp   = {data[qmfr_pkg::Y_HI_BIT], data[qmfr_pkg::Y_LO_BIT]};

	assign q_wdata.buttons = buttons_q;
	assign q_wdata.dx      = prev_x_q - count_x_q;
	assign q_wdata.dy      = prev_y_q - count_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_x_q <= '0;
			count_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			phase_x_q <= '0;
			phase_y_q <= '0;
			buttons_q <= '0;
		end else if (accept) begin
			if (is_tick) begin
				prev_x_q <= count_x_q;
				prev_y_q <= count_y_q;
			end else begin
				if (xp == qmfr_pkg::step_up(phase_x_q)) begin
					count_x_q <= count_x_q + 8'd1;
					phase_x_q <= xp;
				end else if (xp == qmfr_pkg::step_down(phase_x_q)) begin
					count_x_q <= count_x_q - 8'd1;
					phase_x_q <= xp;
				end
				if (yp == qmfr_pkg::step_up(phase_y_q)) begin
					count_y_q <= count_y_q + 8'd1;
					phase_y_q <= yp;
				end else if (yp == qmfr_pkg::step_down(phase_y_q)) begin
					count_y_q <= count_y_q - 8'd1;
					phase_y_q <= yp;
				end
				buttons_q <= {~item.third_button_pin, data[qmfr_pkg::BTN1_BIT],
					data[qmfr_pkg::BTN0_BIT]};
			end
		end
	end

endmodule

[rtl/core/qmfr_queue.sv]
module qmfr_queue #(
	parameter int DEPTH = qmfr_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qmfr_pkg::report_t  wdata,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output qmfr_pkg::report_t  rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	qmfr_pkg::report_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

[rtl/core/qmfr_back.sv]
module qmfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  qmfr_pkg::report_t   q_rdata,
	output logic               q_pop,
	output logic               report_valid,
	input  logic               report_ready,
	output qmfr_pkg::out_item_t report
);

	localparam int IDX_W = qmfr_pkg::IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(qmfr_pkg::REPORT_LEN - 1);
	localparam logic [IDX_W-1:0] IDX_DX   = IDX_W'(qmfr_pkg::NUM_BUTTONS);
	localparam logic [IDX_W-1:0] IDX_DY   =
		IDX_W'(qmfr_pkg::NUM_BUTTONS + qmfr_pkg::DELTA_BITS);

	logic               busy_q;
	logic [IDX_W-1:0]   idx_q;
	qmfr_pkg::report_t   rec_q;
	logic               out_valid_q;
	qmfr_pkg::out_item_t out_q;

	logic               load, done;
	logic [2:0]         off_dx, off_dy;
	qmfr_pkg::out_item_t nxt;

	assign load  = busy_q && (!out_valid_q || report_ready);
	assign done  = load && (idx_q == IDX_LAST);
	assign q_pop = q_valid && (!busy_q || done);

	assign off_dx = 3'(idx_q - IDX_DX);
	assign off_dy = 3'(idx_q - IDX_DY);

	always_comb begin
		nxt.last     = 1'b0;
		nxt.out_byte = '0;
		if (idx_q == IDX_LAST) begin
			nxt.out_byte = qmfr_pkg::TERMINATOR;
			nxt.last     = 1'b1;
		end else if (idx_q >= IDX_DY) begin
			nxt.out_byte[0] = rec_q.dy[off_dy];
		end else if (idx_q >= IDX_DX) begin
			nxt.out_byte[0] = rec_q.dx[off_dx];
		end else begin
			nxt.out_byte[0] = rec_q.buttons[idx_q[1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_rdata;
		end
		if (load) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (report_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign report_valid = out_valid_q;
	assign report       = out_q;

	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> out_q.out_byte == qmfr_pkg::TERMINATOR)
		else $error("last byte is not the terminator");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("report index out of range");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> idx_q == '0)
		else $error("index nonzero while idle");
	a_bits_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> out_q.out_byte[7:1] == '0)
		else $error("report bit byte not 0 or 1");

endmodule
